>>> rtl/framebuffer_rect_blit_engine_macros.svh
// Assertion macros for the framebuffer rectangle blit engine.
// Included by the top level; no other dependencies.
// Bodies are empty when SYNTHESIS is defined.
`ifndef FRAMEBUFFER_RECT_BLIT_ENGINE_MACROS_SVH
`define FRAMEBUFFER_RECT_BLIT_ENGINE_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication
`define FB_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fb blit engine: same-cycle check failed");

// Next-cycle implication
`define FB_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fb blit engine: next-cycle check failed");

`else

`define FB_ASSERT_IMP(label, clk, rst, ante, cons)
`define FB_ASSERT_NXT(label, clk, rst, ante, cons)

`endif

`endif

>>> rtl/fbrb_pkg.sv
// Shared widths, command codes and constants of the framebuffer blit engine.
// No dependencies.
package fbrb_pkg;

   localparam int FUNC_W      = 3;
   localparam int COORD_W     = 11;
   localparam int SIZE_W      = 10;
   localparam int PIXEL_W     = 32;
   localparam int CSR_DATA_W  = 9;
   localparam int CSR_INDEX_W = 1;
   // signed working width of the clipping arithmetic
   localparam int CLIP_W      = 14;

   localparam int DEF_MAX_WIDTH  = 256;
   localparam int DEF_MAX_HEIGHT = 256;

   localparam logic [CSR_DATA_W-1:0] CSR_SIZE_RESET = 9'd256;
   localparam logic [PIXEL_W-1:0]    ALPHA_MASK     = 32'hff00_0000;
   localparam logic signed [CLIP_W-1:0] CLIP_ONE    = 14'sd1;

   // command codes
   localparam logic [FUNC_W-1:0] FUNC_WRITE = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_READ  = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_FILL  = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_COPY  = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_TEST  = 3'd4;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT = 1'b1;

endpackage

>>> rtl/fbrb_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module fbrb_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/framebuffer_rect_blit_engine.sv
// Framebuffer rectangle blit engine, top level.
// Depends on fbrb_pkg, fbrb_ram and framebuffer_rect_blit_engine_macros.svh.
//
// Usage:
//  - req_* carries one command (write/read pixel, fill, masked recolour copy,
//    transparency test). req_ready is high only while the engine is idle.
//  - rsp_* returns exactly one result per request, held in an output
//    register until rsp_ready; the next request may be taken meanwhile.
//  - csr_* writes image_width (index 0) or image_height (index 1); write
//    only while no request is in flight.
//  - A request whose rectangle clips to nothing (or an unused code) skips
//    the walk and goes from the clip states straight to its result.
//    Otherwise the clipped rectangle is walked at one pixel per cycle and
//    then drained before the result is loaded.
//    The engine is ready again as soon as the result is loaded. The pixel
//    rate is set by the frame RAM's single read port and single write port.
//  - A finished result waits in its final state while the previous result
//    is still unread by the receiver.
//  - Reset restores image size 256 x 256 and idles the engine. The frame
//    RAM is not cleared; pixels hold nothing defined until written.
`include "framebuffer_rect_blit_engine_macros.svh"

module framebuffer_rect_blit_engine #(
   parameter int MAX_WIDTH  = fbrb_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = fbrb_pkg::DEF_MAX_HEIGHT
) (
   input  logic                                     clock,
   input  logic                                     reset,
   // request channel
   input  logic                                     req_valid,
   output logic                                     req_ready,
   input  logic        [fbrb_pkg::FUNC_W-1:0]       req_func,
   input  logic signed [fbrb_pkg::COORD_W-1:0]      req_dst_x,
   input  logic signed [fbrb_pkg::COORD_W-1:0]      req_dst_y,
   input  logic signed [fbrb_pkg::COORD_W-1:0]      req_src_x,
   input  logic signed [fbrb_pkg::COORD_W-1:0]      req_src_y,
   input  logic        [fbrb_pkg::SIZE_W-1:0]       req_rect_width,
   input  logic        [fbrb_pkg::SIZE_W-1:0]       req_rect_height,
   input  logic        [fbrb_pkg::PIXEL_W-1:0]      req_color,
   // response channel
   output logic                                     rsp_valid,
   input  logic                                     rsp_ready,
   output logic        [fbrb_pkg::PIXEL_W-1:0]      rsp_read_data,
   output logic                                     rsp_is_transparent,
   output logic                                     rsp_clipped_empty,
   // configuration write port
   input  logic                                     csr_write_en,
   input  logic        [fbrb_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic        [fbrb_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   import fbrb_pkg::*;

   localparam int XW = $clog2(MAX_WIDTH);
   localparam int YW = $clog2(MAX_HEIGHT);
   localparam int AW = $clog2(MAX_WIDTH * MAX_HEIGHT);

   typedef enum logic [6:0] {
      S_IDLE  = 7'b000_0001,
      S_CLIP1 = 7'b000_0010,
      S_CLIP2 = 7'b000_0100,
      S_SETUP = 7'b000_1000,
      S_RUN   = 7'b001_0000,
      S_DRAIN = 7'b010_0000,
      S_DONE  = 7'b100_0000
   } state_type;

   typedef logic signed [CLIP_W-1:0] clip_type;

   // control and configuration registers
   state_type               state_ff, state_in;
   logic [CSR_DATA_W-1:0]   img_w_ff, img_h_ff;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    p1_valid_ff, p1_valid_in;

   // command and walk registers
   logic [FUNC_W-1:0]       func_ff, func_in;
   logic [PIXEL_W-1:0]      color_ff, color_in;
   clip_type                dx_ff, dx_in, dy_ff, dy_in;
   clip_type                sx_ff, sx_in, sy_ff, sy_in;
   clip_type                w_ff, w_in, h_ff, h_in;
   logic                    empty_ff, empty_in;
   logic [XW-1:0]           col_ff, col_in, wm1_ff, wm1_in;
   logic [YW-1:0]           row_ff, row_in, hm1_ff, hm1_in;
   logic [AW-1:0]           d_row_ff, d_row_in, d_ptr_ff, d_ptr_in;
   logic [AW-1:0]           s_row_ff, s_row_in, s_ptr_ff, s_ptr_in;
   logic [AW-1:0]           p1_daddr_ff, p1_daddr_in;
   logic                    fwd_ff, fwd_in;
   logic                    transp_ff, transp_in;
   logic [PIXEL_W-1:0]      rd_acc_ff, rd_acc_in;
   logic [PIXEL_W-1:0]      rsp_data_ff, rsp_data_in;
   logic                    rsp_transp_ff, rsp_transp_in;
   logic                    rsp_empty_ff, rsp_empty_in;

   // combinational
   clip_type                iw_s, ih_s;
   logic [XW:0]             eff_w;
   clip_type                sxa, wa, dxa, dxb, wb, sxb;
   clip_type                sya, ha, dya, dyb, hb, syb;
   clip_type                w3, w4, h3, h4;
   logic [YW+XW:0]          d_prod, s_prod;
   logic                    func_ok;
   logic                    ram_we, ram_re;
   logic [AW-1:0]           ram_waddr, ram_raddr;
   logic [PIXEL_W-1:0]      ram_q, pix;
   logic                    last_col, last_row;

   // effective image size, saturated to the store's geometry
   assign iw_s = (CLIP_W'(img_w_ff) > CLIP_W'(MAX_WIDTH)) ?
                 CLIP_W'(MAX_WIDTH) : CLIP_W'(img_w_ff);
   assign ih_s = (CLIP_W'(img_h_ff) > CLIP_W'(MAX_HEIGHT)) ?
                 CLIP_W'(MAX_HEIGHT) : CLIP_W'(img_h_ff);
   assign eff_w = iw_s[XW:0];

   // clip step 1: pull negative origins to zero, shifting the other rect
   assign sxa = dx_ff[CLIP_W-1] ? sx_ff - dx_ff : sx_ff;
   assign wa  = dx_ff[CLIP_W-1] ? w_ff + dx_ff  : w_ff;
   assign dxa = dx_ff[CLIP_W-1] ? '0 : dx_ff;
   assign dxb = sxa[CLIP_W-1] ? dxa - sxa : dxa;
   assign wb  = sxa[CLIP_W-1] ? wa + sxa  : wa;
   assign sxb = sxa[CLIP_W-1] ? '0 : sxa;

   assign sya = dy_ff[CLIP_W-1] ? sy_ff - dy_ff : sy_ff;
   assign ha  = dy_ff[CLIP_W-1] ? h_ff + dy_ff  : h_ff;
   assign dya = dy_ff[CLIP_W-1] ? '0 : dy_ff;
   assign dyb = sya[CLIP_W-1] ? dya - sya : dya;
   assign hb  = sya[CLIP_W-1] ? ha + sya  : ha;
   assign syb = sya[CLIP_W-1] ? '0 : sya;

   // clip step 2: trim right and bottom edges against both rectangles
   assign w3 = (dx_ff > iw_s - w_ff) ? iw_s - dx_ff : w_ff;
   assign w4 = (sx_ff > iw_s - w3)   ? iw_s - sx_ff : w3;
   assign h3 = (dy_ff > ih_s - h_ff) ? ih_s - dy_ff : h_ff;
   assign h4 = (sy_ff > ih_s - h3)   ? ih_s - sy_ff : h3;

   // row-major start addresses
   assign d_prod = dy_ff[YW-1:0] * eff_w;
   assign s_prod = sy_ff[YW-1:0] * eff_w;

   assign func_ok  = (func_ff <= FUNC_TEST);
   assign last_col = (col_ff == wm1_ff);
   assign last_row = (row_ff == hm1_ff);
   // pixel returned by the RAM, or the one written over it in the same cycle
   assign pix = fwd_ff ? color_ff : ram_q;

   always_comb begin
      state_in      = state_ff;
      rsp_valid_in  = rsp_ready ? 1'b0 : rsp_valid_ff;
      p1_valid_in   = 1'b0;
      func_in       = func_ff;
      color_in      = color_ff;
      dx_in         = dx_ff;
      dy_in         = dy_ff;
      sx_in         = sx_ff;
      sy_in         = sy_ff;
      w_in          = w_ff;
      h_in          = h_ff;
      empty_in      = empty_ff;
      col_in        = col_ff;
      row_in        = row_ff;
      wm1_in        = wm1_ff;
      hm1_in        = hm1_ff;
      d_row_in      = d_row_ff;
      d_ptr_in      = d_ptr_ff;
      s_row_in      = s_row_ff;
      s_ptr_in      = s_ptr_ff;
      p1_daddr_in   = d_ptr_ff;
      transp_in     = transp_ff;
      rd_acc_in     = rd_acc_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_transp_in = rsp_transp_ff;
      rsp_empty_in  = rsp_empty_ff;
      ram_we        = 1'b0;
      ram_re        = 1'b0;
      ram_waddr     = d_ptr_ff;
      ram_raddr     = d_ptr_ff;

      // second half of a read: pixel data is back from the RAM
      if (p1_valid_ff) begin
         case (func_ff)
            FUNC_COPY: begin
               if ((pix & ALPHA_MASK) != '0) begin
                  ram_we    = 1'b1;
                  ram_waddr = p1_daddr_ff;
               end
            end
            FUNC_TEST: begin
               if ((pix & ALPHA_MASK) != '0) begin
                  transp_in = 1'b0;
               end
            end
            FUNC_READ: begin
               rd_acc_in = pix;
            end
            default: begin
            end
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               func_in  = req_func;
               color_in = req_color;
               dx_in    = CLIP_W'(req_dst_x);
               dy_in    = CLIP_W'(req_dst_y);
               // single-pixel commands are a one by one rectangle
               if (req_func == FUNC_WRITE || req_func == FUNC_READ) begin
                  w_in = CLIP_ONE;
                  h_in = CLIP_ONE;
               end else begin
                  w_in = clip_type'(CLIP_W'(req_rect_width));
                  h_in = clip_type'(CLIP_W'(req_rect_height));
               end
               // only the copy has a separate source
               if (req_func == FUNC_COPY) begin
                  sx_in = CLIP_W'(req_src_x);
                  sy_in = CLIP_W'(req_src_y);
               end else begin
                  sx_in = CLIP_W'(req_dst_x);
                  sy_in = CLIP_W'(req_dst_y);
               end
               state_in = S_CLIP1;
            end
         end
         S_CLIP1: begin
            dx_in    = dxb;
            sx_in    = sxb;
            w_in     = wb;
            dy_in    = dyb;
            sy_in    = syb;
            h_in     = hb;
            state_in = S_CLIP2;
         end
         S_CLIP2: begin
            w_in     = w4;
            h_in     = h4;
            empty_in = (w4 < CLIP_ONE) || (h4 < CLIP_ONE);
            if ((w4 < CLIP_ONE) || (h4 < CLIP_ONE) || !func_ok) begin
               state_in = S_DONE;
            end else begin
               state_in = S_SETUP;
            end
         end
         S_SETUP: begin
            wm1_in    = w_ff[XW-1:0] - XW'(1);
            hm1_in    = h_ff[YW-1:0] - YW'(1);
            col_in    = '0;
            row_in    = '0;
            d_row_in  = AW'(d_prod) + AW'(dx_ff[XW-1:0]);
            d_ptr_in  = AW'(d_prod) + AW'(dx_ff[XW-1:0]);
            s_row_in  = AW'(s_prod) + AW'(sx_ff[XW-1:0]);
            s_ptr_in  = AW'(s_prod) + AW'(sx_ff[XW-1:0]);
            transp_in = 1'b1;
            state_in  = S_RUN;
         end
         S_RUN: begin
            // issue one pixel
            case (func_ff)
               FUNC_WRITE, FUNC_FILL: begin
                  ram_we    = 1'b1;
                  ram_waddr = d_ptr_ff;
               end
               FUNC_READ, FUNC_TEST: begin
                  ram_re    = 1'b1;
                  ram_raddr = d_ptr_ff;
               end
               FUNC_COPY: begin
                  ram_re    = 1'b1;
                  ram_raddr = s_ptr_ff;
               end
               default: begin
               end
            endcase
            p1_valid_in = ram_re;
            // advance row-major
            if (last_col) begin
               col_in = '0;
               if (last_row) begin
                  state_in = S_DRAIN;
               end else begin
                  row_in   = row_ff + YW'(1);
                  d_row_in = d_row_ff + AW'(eff_w);
                  d_ptr_in = d_row_ff + AW'(eff_w);
                  s_row_in = s_row_ff + AW'(eff_w);
                  s_ptr_in = s_row_ff + AW'(eff_w);
               end
            end else begin
               col_in   = col_ff + XW'(1);
               d_ptr_in = d_ptr_ff + AW'(1);
               s_ptr_in = s_ptr_ff + AW'(1);
            end
         end
         S_DRAIN: begin
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_data_in   = (func_ff == FUNC_READ && !empty_ff) ? rd_acc_ff : '0;
               rsp_transp_in = (func_ff == FUNC_TEST) && !empty_ff && transp_ff;
               rsp_empty_in  = func_ok && empty_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // a read that meets a write to the same pixel takes the new value
      fwd_in = ram_re && ram_we && (ram_raddr == ram_waddr);
   end

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         img_w_ff     <= CSR_SIZE_RESET;
         img_h_ff     <= CSR_SIZE_RESET;
         rsp_valid_ff <= 1'b0;
         p1_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         p1_valid_ff  <= p1_valid_in;
         if (csr_write_en) begin
            case (csr_index)
               CSR_IMAGE_WIDTH:  img_w_ff <= csr_wdata;
               CSR_IMAGE_HEIGHT: img_h_ff <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      func_ff       <= func_in;
      color_ff      <= color_in;
      dx_ff         <= dx_in;
      dy_ff         <= dy_in;
      sx_ff         <= sx_in;
      sy_ff         <= sy_in;
      w_ff          <= w_in;
      h_ff          <= h_in;
      empty_ff      <= empty_in;
      col_ff        <= col_in;
      row_ff        <= row_in;
      wm1_ff        <= wm1_in;
      hm1_ff        <= hm1_in;
      d_row_ff      <= d_row_in;
      d_ptr_ff      <= d_ptr_in;
      s_row_ff      <= s_row_in;
      s_ptr_ff      <= s_ptr_in;
      p1_daddr_ff   <= p1_daddr_in;
      fwd_ff        <= fwd_in;
      transp_ff     <= transp_in;
      rd_acc_ff     <= rd_acc_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_transp_ff <= rsp_transp_in;
      rsp_empty_ff  <= rsp_empty_in;
   end

   // frame store
   fbrb_ram #(
      .WIDTH (PIXEL_W),
      .DEPTH (MAX_WIDTH * MAX_HEIGHT)
   ) u_frame_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (color_ff),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_q)
   );

   assign req_ready          = (state_ff == S_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_read_data      = rsp_data_ff;
   assign rsp_is_transparent = rsp_transp_ff;
   assign rsp_clipped_empty  = rsp_empty_ff;

   // checks
   `FB_ASSERT_IMP(a_we_in_walk, clock, reset, ram_we,
      (state_ff == S_RUN) || (state_ff == S_DRAIN))
   `FB_ASSERT_NXT(a_read_returns, clock, reset, (state_ff == S_RUN) && ram_re, p1_valid_ff)
   `FB_ASSERT_NXT(a_done_loads, clock, reset, (state_ff == S_DONE) && !rsp_valid_ff,
      rsp_valid_ff && (state_ff == S_IDLE))
   `FB_ASSERT_IMP(a_empty_not_transp, clock, reset, rsp_valid_ff && rsp_empty_ff,
      !rsp_transp_ff)

endmodule
